[rtl/uts_pkg.sv]
package uts_pkg;

   // byte codes
   localparam logic [7:0] CODE_TAB      = 8'h09;
   localparam logic [7:0] CODE_LF       = 8'h0A;
   localparam logic [7:0] CODE_CR       = 8'h0D;
   localparam logic [7:0] CODE_SPACE    = 8'h20;
   localparam logic [7:0] CODE_QUESTION = 8'h3F;
   localparam logic [7:0] CODE_ASCII_END = 8'h80;

   // UTF-8 lead and continuation bounds
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] LEAD4_HI  = 8'hF4;
   localparam logic [7:0] LEAD_SURR = 8'hED;
   localparam logic [7:0] CONT_A0   = 8'hA0;
   localparam logic [7:0] CONT_90   = 8'h90;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
   localparam int unsigned QUEUE_DEPTH = 2;

   // one accepted byte's worth of results
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;      // 0 = bare end marker
      logic            fin;
      logic            cut;
      logic [15:0]     full_size;
   } bundle_type;

endpackage

[rtl/uts_front.sv]
module uts_front #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_final_byte,
   input  logic [15:0]         emit_cap,
   input  logic                q_ready,
   output logic                push,
   output uts_pkg::bundle_type push_data
);

   localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [7:0]            held_ff [3];
   logic [7:0]            held_in [3];
   logic [1:0]            hc_ff, hc_in;
   logic [2:0]            need_ff, need_in;
   logic                  swallow_ff, swallow_in;
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic [COUNT_BITS-1:0] full_ff, full_in;
   logic                  stopped_ff, stopped_in;

   logic       accept;
   logic [7:0] b;
   logic       skip;
   logic       fresh_emit, fresh_lead, fresh_cr;
   logic [7:0] fresh_val;
   logic [2:0] fresh_need;
   logic       cont_ok;
   logic       use_fresh, seq;
   logic [1:0] flush_n;
   logic [2:0] k, n_put, seq_len, room, ne;
   logic [3:0][7:0] list;
   logic       stop_new;
   logic [CW-1:0] lim_eff, em_ext, diff, full_ext;
   logic [COUNT_BITS:0]   full_sum;
   logic [COUNT_BITS-1:0] emitted_new, full_new;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign b         = req_in_byte;
   assign skip      = swallow_ff && (b == uts_pkg::CODE_LF) && (hc_ff == 2'd0);

   // classify a byte taken as a new start
   always_comb begin
      fresh_emit = 1'b0;
      fresh_val  = uts_pkg::CODE_QUESTION;
      fresh_lead = 1'b0;
      fresh_need = 3'd0;
      fresh_cr   = 1'b0;
      if (b == uts_pkg::CODE_CR) begin
         fresh_emit = 1'b1;
         fresh_val  = uts_pkg::CODE_LF;
         fresh_cr   = 1'b1;
      end else if (b < uts_pkg::CODE_SPACE && b != uts_pkg::CODE_LF && b != uts_pkg::CODE_TAB) begin
         fresh_emit = 1'b1;
      end else if (b < uts_pkg::CODE_ASCII_END) begin
         fresh_emit = 1'b1;
         fresh_val  = b;
      end else if (b >= uts_pkg::LEAD2_LO && b <= uts_pkg::LEAD4_HI) begin
         fresh_lead = 1'b1;
         fresh_need = (b <= uts_pkg::LEAD2_HI) ? 3'd2 : (b <= uts_pkg::LEAD3_HI) ? 3'd3 : 3'd4;
      end else begin
         fresh_emit = 1'b1;
      end
   end

   always_comb begin
      cont_ok = ((b & uts_pkg::CONT_MASK) == uts_pkg::CONT_TAG);
      if (hc_ff == 2'd1) begin
         if ((held_ff[0] == uts_pkg::LEAD3_LO  && b <  uts_pkg::CONT_A0) ||
             (held_ff[0] == uts_pkg::LEAD_SURR && b >= uts_pkg::CONT_A0) ||
             (held_ff[0] == uts_pkg::LEAD4_LO  && b <  uts_pkg::CONT_90) ||
             (held_ff[0] == uts_pkg::LEAD4_HI  && b >= uts_pkg::CONT_90)) begin
            cont_ok = 1'b0;
         end
      end
   end

   // sequence tracking and the list of bytes this transaction produces
   always_comb begin
      held_in    = held_ff;
      hc_in      = hc_ff;
      need_in    = need_ff;
      swallow_in = 1'b0;
      use_fresh  = 1'b0;
      seq        = 1'b0;
      flush_n    = 2'd0;
      seq_len    = {1'b0, hc_ff} + 3'd1;
      if (!skip) begin
         if (hc_ff == 2'd0) begin
            use_fresh = 1'b1;
         end else if (cont_ok) begin
            if (seq_len >= need_ff) begin
               seq     = 1'b1;
               hc_in   = 2'd0;
               need_in = 3'd0;
            end else begin
               held_in[hc_ff] = b;
               hc_in          = 2'(seq_len);
            end
         end else begin
            flush_n   = hc_ff;
            use_fresh = 1'b1;
         end
      end
      if (use_fresh) begin
         swallow_in = fresh_cr;
         if (fresh_lead) begin
            held_in[0] = b;
            hc_in      = 2'd1;
            need_in    = fresh_need;
         end else begin
            hc_in   = 2'd0;
            need_in = 3'd0;
         end
      end
      k = {1'b0, flush_n} + {2'b00, use_fresh && fresh_emit}
          + (req_final_byte ? {1'b0, hc_in} : 3'd0);
      for (int i = 0; i < 4; i++) begin
         if (seq) begin
            list[i] = (i < int'(hc_ff)) ? held_ff[i < 3 ? i : 2] : b;
         end else if (use_fresh && fresh_emit && i == int'(flush_n)) begin
            list[i] = fresh_val;
         end else begin
            list[i] = uts_pkg::CODE_QUESTION;
         end
      end
   end

   // output limit and size counting
   always_comb begin
      lim_eff = (CW'(emit_cap) < CW'(COUNT_MAX)) ? CW'(emit_cap) : CW'(COUNT_MAX);
      em_ext  = CW'(emitted_ff);
      diff    = (lim_eff > em_ext) ? (lim_eff - em_ext) : '0;
      room    = stopped_ff ? 3'd0 : ((diff > CW'(7)) ? 3'd7 : diff[2:0]);
      n_put   = seq ? seq_len : k;
      if (seq) begin
         stop_new = stopped_ff || (seq_len > room);
         ne       = stop_new ? 3'd0 : seq_len;
      end else begin
         stop_new = stopped_ff || (k > room);
         ne       = (k < room) ? k : room;
      end
      emitted_new = emitted_ff + COUNT_BITS'(ne);
      full_sum    = {1'b0, full_ff} + (COUNT_BITS+1)'(n_put);
      full_new    = full_sum[COUNT_BITS] ? COUNT_MAX : full_sum[COUNT_BITS-1:0];
      full_ext    = CW'(full_new);
   end

   always_comb begin
      push_data.data      = list;
      push_data.count     = ne;
      push_data.fin       = req_final_byte;
      push_data.cut       = stop_new;
      push_data.full_size = (full_ext > CW'(16'hFFFF)) ? 16'hFFFF : full_ext[15:0];
      push                = accept && (ne != 3'd0 || req_final_byte);
      emitted_in          = emitted_new;
      full_in             = full_new;
      stopped_in          = stop_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff      <= 2'd0;
         need_ff    <= 3'd0;
         swallow_ff <= 1'b0;
         emitted_ff <= '0;
         full_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         if (req_final_byte) begin
            hc_ff      <= 2'd0;
            need_ff    <= 3'd0;
            swallow_ff <= 1'b0;
            emitted_ff <= '0;
            full_ff    <= '0;
            stopped_ff <= 1'b0;
         end else begin
            hc_ff      <= hc_in;
            need_ff    <= need_in;
            swallow_ff <= swallow_in;
            emitted_ff <= emitted_in;
            full_ff    <= full_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // an open sequence is always shorter than its announced length
   a_open_seq_short: assert property (@(posedge clock) disable iff (reset)
      (hc_ff != 2'd0) |-> (need_ff > {1'b0, hc_ff}))
      else $error("open sequence not shorter than its length");

   // a final byte always leaves the tracker clear
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (hc_ff == 2'd0 && emitted_ff == '0 && !stopped_ff))
      else $error("state not cleared after message end");

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready)
      else $error("push without queue space");

endmodule

[rtl/uts_queue.sv]
module uts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uts_pkg::bundle_type push_data,
   output logic                q_ready,
   output logic                q_valid,
   output uts_pkg::bundle_type q_data,
   input  logic                pop
);

   uts_pkg::bundle_type mem_ff [uts_pkg::QUEUE_DEPTH];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign q_ready = (count_ff != 2'(uts_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop  ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'(uts_pkg::QUEUE_DEPTH)))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("queue underflow");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(uts_pkg::QUEUE_DEPTH)) |-> (wr_ff == rd_ff))
      else $error("pointers disagree with fill level");

endmodule

[rtl/uts_back.sv]
module uts_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  uts_pkg::bundle_type q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_message_end,
   output logic                rsp_was_cut,
   output logic [15:0]         rsp_full_size
);

   uts_pkg::bundle_type cur_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] last_idx;
   logic       last, load;

   always_comb begin
      last_idx = (cur_ff.count == 3'd0) ? 2'd0 : 2'(cur_ff.count - 3'd1);
      last     = (idx_ff == last_idx);
      load     = !valid_ff || (rsp_ready && last);
      pop      = load && q_valid;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = q_valid;
         idx_in   = 2'd0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid       = valid_ff;
      rsp_byte_valid  = (cur_ff.count != 3'd0);
      rsp_out_byte    = rsp_byte_valid ? cur_ff.data[idx_ff] : 8'h00;
      rsp_message_end = cur_ff.fin && last;
      rsp_was_cut     = rsp_message_end ? cur_ff.cut : 1'b0;
      rsp_full_size   = rsp_message_end ? cur_ff.full_size : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_data;
      end
   end

   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_message_end && rsp_out_byte == 8'h00))
      else $error("bare marker without message end");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff <= last_idx))
      else $error("result index past bundle");

   a_no_tail_info: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_message_end) |-> (!rsp_was_cut && rsp_full_size == 16'h0000))
      else $error("size info outside message end");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

[rtl/utf8_text_sanitizer_unit.sv]
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | req_in_byte[7:0], req_final_byte
// rsp     | out | rsp_valid/rsp_ready | rsp_out_byte[7:0], rsp_byte_valid, rsp_message_end,
//         |     |                     | rsp_was_cut, rsp_full_size[15:0]
// csr     | in  | APB psel/penable    | byte cap at byte address 0, pready tied high
//
// One req transaction per cycle is accepted while the two-entry queue has room.
// A transaction yields 0 to 4 rsp transactions; the back end sends one per cycle while
// rsp_ready is high, so the single rsp port sets the output rate.
// Synchronous active-high reset clears sequence state, counters, queue and rsp_valid;
// the byte cap returns to 65535. No clearing pass is needed.
// Either side may stall independently: the queue decouples classification from delivery.
module utf8_text_sanitizer_unit #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_message_end,
   output logic        rsp_was_cut,
   output logic [15:0] rsp_full_size,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // word index of the only register
   localparam logic REG_EMIT_CAP = 1'b0;

   logic [15:0]         limit_ff, limit_in;
   logic                csr_write;
   logic                push, pop, q_ready, q_valid;
   uts_pkg::bundle_type push_data, q_data;

   // register file: writes complete in the access phase, pready always high
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && csr_paddr[2] == REG_EMIT_CAP) begin
         limit_in = csr_pwdata[15:0];
      end
      csr_prdata = (csr_paddr[2] == REG_EMIT_CAP) ? {16'h0000, limit_ff} : 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= uts_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // front end: sequence checking, CR/LF folding, limit and size accounting
   uts_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .emit_cap       (limit_ff),
      .q_ready        (q_ready),
      .push           (push),
      .push_data      (push_data)
   );

   // holds bundles of up to four result bytes per req transaction
   uts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_ready   (q_ready),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop)
   );

   // back end: one rsp transaction per cycle from the current bundle while rsp_ready is high
   uts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end),
      .rsp_was_cut     (rsp_was_cut),
      .rsp_full_size   (rsp_full_size)
   );

   // the limit only moves under a completed write
   a_limit_stable: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) |-> $stable(limit_ff))
      else $error("limit changed without a write");

   a_pready_high: assert property (@(posedge clock)
      csr_pready)
      else $error("pready low");

   a_reset_limit: assert property (@(posedge clock)
      $past(reset) |-> (limit_ff == uts_pkg::LIMIT_RESET))
      else $error("limit not at reset value");

endmodule

[tb/sv/utf8_sanitizer_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port. Predicts the cleaned bytes of
// every accepted input transaction and compares each result transaction in order.
module utf8_sanitizer_checker #(
   parameter int unsigned COUNT_BITS = 16,
   parameter logic [2:0]  LIMIT_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_final_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_message_end,
   input  logic        rsp_was_cut,
   input  logic [15:0] rsp_full_size,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int unsigned mismatches,
   output int unsigned pending_results
);

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam int unsigned     PRINT_CAP = 40;

   typedef struct packed {
      logic [7:0]  data;
      logic        valid;
      logic        last;
      logic        cut;
      logic [15:0] size;
   } cleaned_type;

   cleaned_type     cleaned_expected[$];
   logic [7:0]      step_bytes[$];
   logic [7:0]      open_seq[3];
   int unsigned     open_len;
   int unsigned     seq_len;
   bit              lf_pending;
   bit              halted;
   longint unsigned emitted_n;
   longint unsigned cleaned_n;
   logic [15:0]     limit_reg;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("[%0t] sanitizer mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] seen,
                                input logic [15:0] wanted);
      if (seen !== wanted)
         report_mismatch($sformatf("%s got %0h, want %0h", name, seen, wanted));
   endtask

   function automatic void tally(input longint unsigned n);
      cleaned_n += n;
      if (cleaned_n > COUNT_MAX) cleaned_n = COUNT_MAX;
   endfunction

   function automatic void put_char(input logic [7:0] b);
      tally(1);
      if (halted) return;
      if (emitted_n < limit_reg && emitted_n < COUNT_MAX) begin
         step_bytes.push_back(b);
         emitted_n++;
      end else begin
         halted = 1'b1;
      end
   endfunction

   // whole sequence or nothing; a misfit stops output for the message
   function automatic void put_seq(input logic [3:0][7:0] seq, input int unsigned len);
      if (halted || emitted_n + len > limit_reg || emitted_n + len > COUNT_MAX) begin
         halted = 1'b1;
      end else begin
         for (int k = 0; k < len; k++) step_bytes.push_back(seq[k]);
         emitted_n += len;
      end
      tally(len);
   endfunction

   function automatic void flush_open();
      for (int k = 0; k < open_len; k++) put_char(uts_pkg::CODE_QUESTION);
      open_len = 0;
      seq_len  = 0;
   endfunction

   function automatic void start_byte(input logic [7:0] b);
      if (b == uts_pkg::CODE_CR) begin
         put_char(uts_pkg::CODE_LF);
         lf_pending = 1'b1;
      end else if (b < uts_pkg::CODE_SPACE && b != uts_pkg::CODE_LF &&
                   b != uts_pkg::CODE_TAB) begin
         put_char(uts_pkg::CODE_QUESTION);
      end else if (b < uts_pkg::CODE_ASCII_END) begin
         put_char(b);
      end else if (b >= uts_pkg::LEAD2_LO && b <= uts_pkg::LEAD4_HI) begin
         open_seq[0] = b;
         open_len    = 1;
         seq_len     = (b <= uts_pkg::LEAD2_HI) ? 2 : (b <= uts_pkg::LEAD3_HI) ? 3 : 4;
      end else begin
         put_char(uts_pkg::CODE_QUESTION);
      end
   endfunction

   function automatic bit cont_ok(input logic [7:0] b);
      logic [7:0] lead;
      lead = open_seq[0];
      if ((b & uts_pkg::CONT_MASK) != uts_pkg::CONT_TAG) return 1'b0;
      if (open_len == 1) begin
         if (lead == uts_pkg::LEAD3_LO  && b <  uts_pkg::CONT_A0) return 1'b0;
         if (lead == uts_pkg::LEAD_SURR && b >= uts_pkg::CONT_A0) return 1'b0;
         if (lead == uts_pkg::LEAD4_LO  && b <  uts_pkg::CONT_90) return 1'b0;
         if (lead == uts_pkg::LEAD4_HI  && b >= uts_pkg::CONT_90) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void clear_message();
      open_len   = 0;
      seq_len    = 0;
      lf_pending = 1'b0;
      emitted_n  = 0;
      cleaned_n  = 0;
      halted     = 1'b0;
   endfunction

   function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
      logic [3:0][7:0] seq;
      cleaned_type     batch[$];
      bit              skip;
      int unsigned     n;
      skip = 1'b0;
      step_bytes.delete();
      if (lf_pending) begin
         lf_pending = 1'b0;
         skip = (b == uts_pkg::CODE_LF && open_len == 0);
      end
      if (!skip) begin
         if (open_len == 0) begin
            start_byte(b);
         end else if (cont_ok(b)) begin
            if (open_len + 1 >= seq_len) begin
               seq = '0;
               for (int k = 0; k < open_len; k++) seq[k] = open_seq[k];
               seq[open_len] = b;
               put_seq(seq, open_len + 1);
               open_len = 0;
               seq_len  = 0;
            end else begin
               open_seq[open_len] = b;
               open_len++;
            end
         end else begin
            flush_open();
            start_byte(b);
         end
      end
      if (fin) flush_open();

      n = (step_bytes.size() > 4) ? 4 : step_bytes.size();
      for (int k = 0; k < n; k++) batch.push_back('{step_bytes[k], 1'b1, 1'b0, 1'b0, 16'h0});
      if (fin) begin
         // bare end marker when the final byte cleans to nothing
         if (n == 0) batch.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 16'h0});
         batch[batch.size() - 1].last = 1'b1;
         batch[batch.size() - 1].cut  = halted;
         batch[batch.size() - 1].size = (cleaned_n > 64'hFFFF) ? 16'hFFFF : cleaned_n[15:0];
         clear_message();
      end
      foreach (batch[k]) cleaned_expected.push_back(batch[k]);
   endfunction

   always @(posedge clock) begin : watch
      cleaned_type got;
      cleaned_type want;
      if (reset) begin
         cleaned_expected.delete();
         clear_message();
         limit_reg = uts_pkg::LIMIT_RESET;
         mismatches = 0;
         pending_results <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LIMIT_ADDR)
            limit_reg = csr_pwdata[15:0];
         if (req_valid && req_ready) sanitize_byte(req_in_byte, req_final_byte);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_byte_valid, rsp_message_end, rsp_was_cut, rsp_full_size};
            if (cleaned_expected.size() == 0) begin
               report_mismatch($sformatf("result %0h arrived with nothing expected", got));
            end else begin
               want = cleaned_expected.pop_front();
               compare_field("out_byte", 16'(got.data), 16'(want.data));
               compare_field("byte_valid", 16'(got.valid), 16'(want.valid));
               compare_field("message_end", 16'(got.last), 16'(want.last));
               compare_field("was_cut", 16'(got.cut), 16'(want.cut));
               compare_field("full_size", got.size, want.size);
            end
         end
         pending_results <= cleaned_expected.size();
      end
   end

endmodule

[tb/sv/tb_utf8_text_sanitizer_unit.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the UTF-8 sanitizer. All checking lives in the checker
// instance beside the DUT; this module only builds messages, drives the request
// channel, toggles rsp_ready and reprograms the byte cap between messages.
module tb_utf8_text_sanitizer_unit;

   localparam int unsigned COUNT_BITS    = 16;
   localparam logic [2:0]  ADDR_EMIT_CAP = 3'd0;
   localparam int unsigned SETTLE_CYCLES = 10;    // queue plus pipeline, with margin
   localparam int unsigned MSGS_PER_MODE = 4;

   // byte bounds used when building sequences
   localparam logic [7:0] CONT_TOP        = 8'hBF;
   localparam logic [7:0] SURR_SECOND_TOP = 8'h9F;
   localparam logic [7:0] F4_SECOND_TOP   = 8'h8F;
   localparam logic [7:0] ASCII_TOP       = 8'h7F;
   localparam logic [7:0] CTRL_TOP        = 8'h1F;
   localparam logic [7:0] LEAD_BAD_HI     = 8'hC1;
   localparam logic [7:0] LEAD_BAD_LO     = 8'hF5;
   localparam logic [7:0] BYTE_TOP        = 8'hFF;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte    = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_message_end;
   logic        rsp_was_cut;
   logic [15:0] rsp_full_size;
   logic        csr_psel       = 1'b0;
   logic        csr_penable    = 1'b0;
   logic        csr_pwrite     = 1'b0;
   logic [2:0]  csr_paddr      = 3'd0;
   logic [31:0] csr_pwdata     = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned mismatches;
   int unsigned pending_results;

   // idle rates in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // run statistics for the closing summary
   int unsigned bytes_sent    = 0;
   int unsigned messages_sent = 0;
   int unsigned limits_set    = 0;

   logic [7:0]  message_q[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   utf8_text_sanitizer_unit #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end),
      .rsp_was_cut     (rsp_was_cut),
      .rsp_full_size   (rsp_full_size),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   utf8_sanitizer_checker #(
      .COUNT_BITS (COUNT_BITS),
      .LIMIT_ADDR (ADDR_EMIT_CAP)
   ) sanitizer_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end),
      .rsp_was_cut     (rsp_was_cut),
      .rsp_full_size   (rsp_full_size),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   // Receiver back-pressure: one fresh decision per cycle, a single NBA per edge.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // One request transaction. Valid is left high after acceptance so that back-to-back
   // bytes never lower and raise it in the same step; it only drops on an idle cycle.
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= value;
      req_final_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (message_q[i]) send_byte(message_q[i], i == message_q.size() - 1);
      messages_sent++;
   endtask

   // Quiesce: stop sending, let every predicted transaction come back, then give
   // the block time to finish bytes that were held and produced nothing yet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup phase, then access phase; pready is honoured though tied high.
   task automatic write_limit(input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_EMIT_CAP;
      csr_pwdata  <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      limits_set++;
   endtask

   // Rotates through the extremes (0, 65535, 1), a spread of small limits and a random one,
   // so truncation hits ASCII bytes and multi-byte sequences alike.
   function automatic logic [15:0] pick_limit(input int unsigned idx);
      case (idx % 6)
         0:       return 16'd0;
         1:       return uts_pkg::LIMIT_RESET;
         2:       return 16'd1;
         3:       return 16'($urandom_range(6, 2));
         4:       return 16'($urandom_range(20, 7));
         default: return 16'($urandom);
      endcase
   endfunction

   // Well-formed UTF-8 of the given length with random payload; drop_last leaves
   // it cut short, so the next byte (or the end of message) breaks it.
   function automatic void push_utf8(input int unsigned len, input bit drop_last);
      logic [7:0]  lead;
      logic [7:0]  second;
      int unsigned total;
      total = drop_last ? len - 1 : len;
      case (len)
         2: begin
            lead   = 8'($urandom_range(uts_pkg::LEAD2_HI, uts_pkg::LEAD2_LO));
            second = 8'($urandom_range(CONT_TOP, uts_pkg::CONT_TAG));
         end
         3: begin
            lead = 8'($urandom_range(uts_pkg::LEAD3_HI, uts_pkg::LEAD3_LO));
            if (lead == uts_pkg::LEAD3_LO)
               second = 8'($urandom_range(CONT_TOP, uts_pkg::CONT_A0));
            else if (lead == uts_pkg::LEAD_SURR)
               second = 8'($urandom_range(SURR_SECOND_TOP, uts_pkg::CONT_TAG));
            else
               second = 8'($urandom_range(CONT_TOP, uts_pkg::CONT_TAG));
         end
         default: begin
            lead = 8'($urandom_range(uts_pkg::LEAD4_HI, uts_pkg::LEAD4_LO));
            if (lead == uts_pkg::LEAD4_LO)
               second = 8'($urandom_range(CONT_TOP, uts_pkg::CONT_90));
            else if (lead == uts_pkg::LEAD4_HI)
               second = 8'($urandom_range(F4_SECOND_TOP, uts_pkg::CONT_TAG));
            else
               second = 8'($urandom_range(CONT_TOP, uts_pkg::CONT_TAG));
         end
      endcase
      message_q.push_back(lead);
      if (total >= 2) message_q.push_back(second);
      for (int k = 2; k < total; k++)
         message_q.push_back(8'($urandom_range(CONT_TOP, uts_pkg::CONT_TAG)));
   endfunction

   // Single-byte traffic: printable text, DEL, stray controls, CR, CRLF, LF and tab.
   function automatic void push_plain();
      case ($urandom_range(0, 5))
         0, 1, 2: message_q.push_back(8'($urandom_range(ASCII_TOP, uts_pkg::CODE_SPACE)));
         3:       message_q.push_back(8'($urandom_range(CTRL_TOP, 0)));
         4: begin
            message_q.push_back(uts_pkg::CODE_CR);
            if ($urandom_range(0, 1)) message_q.push_back(uts_pkg::CODE_LF);
         end
         default: message_q.push_back($urandom_range(0, 1) ? uts_pkg::CODE_LF
                                                           : uts_pkg::CODE_TAB);
      endcase
   endfunction

   // Malformed input. Whatever follows is re-examined as a fresh start.
   function automatic void push_broken();
      case ($urandom_range(0, 5))
         0: message_q.push_back($urandom_range(0, 1)
                                ? 8'($urandom_range(LEAD_BAD_HI, uts_pkg::CONT_TAG))
                                : 8'($urandom_range(BYTE_TOP, LEAD_BAD_LO)));
         1: push_utf8($urandom_range(4, 2), 1'b1);
         2: begin   // overlong three-byte form
            message_q.push_back(uts_pkg::LEAD3_LO);
            message_q.push_back(8'($urandom_range(SURR_SECOND_TOP, uts_pkg::CONT_TAG)));
         end
         3: begin   // surrogate
            message_q.push_back(uts_pkg::LEAD_SURR);
            message_q.push_back(8'($urandom_range(CONT_TOP, uts_pkg::CONT_A0)));
         end
         4: begin   // overlong four-byte form or above U+10FFFF
            if ($urandom_range(0, 1)) begin
               message_q.push_back(uts_pkg::LEAD4_LO);
               message_q.push_back(8'($urandom_range(F4_SECOND_TOP, uts_pkg::CONT_TAG)));
            end else begin
               message_q.push_back(uts_pkg::LEAD4_HI);
               message_q.push_back(8'($urandom_range(CONT_TOP, uts_pkg::CONT_90)));
            end
         end
         default: begin   // three held bytes broken by a new lead
            push_utf8(4, 1'b1);
            message_q.push_back(8'($urandom_range(uts_pkg::LEAD4_HI, uts_pkg::LEAD2_LO)));
         end
      endcase
   endfunction

   // Mostly well-formed characters, some plain bytes, a minority of breakage;
   // now and then the message stops inside an open sequence.
   function automatic void build_message(input int unsigned chars);
      message_q.delete();
      repeat (chars) begin
         case ($urandom_range(0, 9))
            0, 1, 2:       push_plain();
            3, 4, 5, 6, 7: push_utf8($urandom_range(4, 2), 1'b0);
            default:       push_broken();
         endcase
      end
      if ($urandom_range(0, 4) == 0) push_utf8($urandom_range(4, 2), 1'b1);
   endfunction

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, limit at its reset value, sender idles lightly, receiver heavily.
      send_idle_pct = 14;
      recv_idle_pct = 81;
      // tab, control, CRLF, lead C2 and the leads E0, ED, F0, F4 at their second-byte bounds
      message_q = '{uts_pkg::CODE_TAB, 8'h00, uts_pkg::CODE_CR, uts_pkg::CODE_LF,
                    uts_pkg::LEAD2_LO, uts_pkg::CONT_TAG,
                    uts_pkg::LEAD3_LO, uts_pkg::CONT_A0, uts_pkg::CONT_TAG,
                    uts_pkg::LEAD_SURR, SURR_SECOND_TOP, CONT_TOP,
                    uts_pkg::LEAD4_LO, uts_pkg::CONT_90, uts_pkg::CONT_TAG, uts_pkg::CONT_TAG,
                    uts_pkg::LEAD4_HI, F4_SECOND_TOP, CONT_TOP, CONT_TOP};
      send_message();
      // overlong, surrogate, above range, then three held bytes broken by a lead
      // that the final byte flushes as well: four results from one transaction
      message_q = '{uts_pkg::LEAD3_LO, SURR_SECOND_TOP, uts_pkg::LEAD_SURR, uts_pkg::CONT_A0,
                    uts_pkg::LEAD4_HI, uts_pkg::CONT_90,
                    uts_pkg::LEAD4_LO, uts_pkg::CONT_90, uts_pkg::CONT_TAG,
                    uts_pkg::LEAD2_LO};
      send_message();
      // LF swallowed on the final byte: bare end marker
      message_q = '{uts_pkg::CODE_CR, uts_pkg::CODE_LF};
      send_message();

      // Random part: three idle regimes, new limit before every message.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int m = 0; m < MSGS_PER_MODE; m++) begin
            drain();
            write_limit(pick_limit(limits_set));
            build_message($urandom_range(5, 1));
            send_message();
         end
      end

      drain();
      $display("Run: %0d messages, %0d bytes, %0d limit writes incl. 0, 1 and 65535,",
               messages_sent, bytes_sent, limits_set);
      $display("stalls on either side and none, broken, cut-off and truncated sequences.");
      if (mismatches == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hang guard: far past the slowest legal run (every byte fanning out to four
   // results under the heaviest receiver stalls).
   initial begin : watchdog
      #(1_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
rtl/uts_pkg.sv
rtl/uts_front.sv
rtl/uts_queue.sv
rtl/uts_back.sv
rtl/utf8_text_sanitizer_unit.sv
tb/sv/utf8_sanitizer_checker.sv
tb/sv/tb_utf8_text_sanitizer_unit.sv
